// ===== design/fwt2_pkg.sv =====
// shared constants and types for the two-dimensional fenwick tree block
`timescale 1ns / 1ps

package fwt2_pkg;

    // default sizing handed to the top level
    localparam int MAX_SIDE_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths
    localparam int GRID_W  = 9;
    localparam int COORD_W = 8;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;

    localparam logic [GRID_W-1:0] GRID_RESET = 9'd256;

    // request codes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_SUM  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // result status codes
    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    // shared adder operation
    typedef enum logic
    {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // memory port control
    typedef struct packed
    {
        logic en;
        logic we;
    } mem_ctl_t;

endpackage

// ===== design/fenwick_tree_2d_rect_sum.sv =====
// top level of the two-dimensional fenwick tree rectangle sum block
// Usage:
//   Requests enter on in_valid/in_stall; a word is taken when in_valid is high
//   and in_stall is low. op selects add (0), set (1) or rectangle sum (2). Each
//   request returns exactly one word on out_valid/out_stall: sum and status. The
//   user writes grid_size via cfg_wr_en/cfg_wr_data while idle; not enforced.
// Timing:
//   One request at a time. A rectangle sum runs four prefix walks, one node read
//   per cycle. An add walks the update path, each node read and then written.
//   A set runs four one-cell walks, a difference step and an update walk.
//   Out-of-range requests and op 3 go straight to the result. The result word is
//   out in the same cycle that the next request fits.
// Reset:
//   rst_n clears control and sets grid_size to 256, then a clearing pass writes
//   zero to all 2^(2*ceil(log2(MAX_SIDE))) tree nodes (65536 at 256);
//   in_stall stays high meanwhile.
// Stall:
//   A finished word waits in the output register; the block takes the next
//   request while it waits, and holds its own result back until the slot frees.
`timescale 1ns / 1ps

module fenwick_tree_2d_rect_sum #(
    parameter int MAX_SIDE   = fwt2_pkg::MAX_SIDE_DEF,
    parameter int VALUE_BITS = fwt2_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [fwt2_pkg::GRID_W-1:0]       cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        op,
    input  logic [fwt2_pkg::COORD_W-1:0]      col_lo,
    input  logic [fwt2_pkg::COORD_W-1:0]      row_lo,
    input  logic [fwt2_pkg::COORD_W-1:0]      col_hi,
    input  logic [fwt2_pkg::COORD_W-1:0]      row_hi,
    input  logic signed [fwt2_pkg::IN_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fwt2_pkg::OUT_W-1:0] sum,
    output logic                              status
);

    localparam int AW = $clog2(MAX_SIDE);

    fwt2_pkg::mem_ctl_t       mem_ctl;
    logic [2*AW-1:0]          mem_addr;
    logic [VALUE_BITS-1:0]    mem_wdata;
    logic [VALUE_BITS-1:0]    mem_rdata;
    fwt2_pkg::alu_op_t        alu_op;
    logic [VALUE_BITS-1:0]    alu_a;
    logic [VALUE_BITS-1:0]    alu_b;
    logic [VALUE_BITS-1:0]    alu_y;

    // sequencer
    fwt2_ctrl #(
        .MAX_SIDE   (MAX_SIDE),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .col_lo      (col_lo),
        .row_lo      (row_lo),
        .col_hi      (col_hi),
        .row_hi      (row_hi),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sum         (sum),
        .status      (status),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .mem_rdata   (mem_rdata),
        .alu_op      (alu_op),
        .alu_a       (alu_a),
        .alu_b       (alu_b),
        .alu_y       (alu_y)
    );

    // tree node storage
    fwt2_mem #(
        .AW (2 * AW),
        .DW (VALUE_BITS)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // shared adder
    fwt2_alu #(
        .DW (VALUE_BITS)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

endmodule

// ===== design/fwt2_mem.sv =====
// single-port tree node memory with registered read data
`timescale 1ns / 1ps

module fwt2_mem #(
    parameter int AW = 16,
    parameter int DW = 32
) (
    input  logic                clk,
    input  fwt2_pkg::mem_ctl_t  ctl,
    input  logic [AW-1:0]       addr,
    input  logic [DW-1:0]       wdata,
    output logic [DW-1:0]       rdata
);

    logic [DW-1:0] mem_arr [2**AW];
    logic [DW-1:0] rdata_reg;

    // one access per cycle, write or read
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
            begin
                mem_arr[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_arr[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/fwt2_alu.sv =====
// shared add/subtract unit used for accumulation, differences and node updates
`timescale 1ns / 1ps

module fwt2_alu #(
    parameter int DW = 32
) (
    input  fwt2_pkg::alu_op_t  op,
    input  logic [DW-1:0]      a,
    input  logic [DW-1:0]      b,
    output logic [DW-1:0]      y
);

    logic          sub;
    logic [DW-1:0] b_inv;

    // one carry chain, subtract by inverting b and carrying in
    always_comb
    begin
        sub   = (op == fwt2_pkg::ALU_SUB);
        b_inv = b ^ {DW{sub}};
        y     = a + b_inv + DW'(sub);
    end

endmodule

// ===== design/fwt2_ctrl.sv =====
// sequencer: clearing pass, prefix queries, tree update walk and result register
`timescale 1ns / 1ps

module fwt2_ctrl #(
    parameter int MAX_SIDE   = fwt2_pkg::MAX_SIDE_DEF,
    parameter int VALUE_BITS = fwt2_pkg::VALUE_BITS_DEF,
    parameter int AW         = $clog2(MAX_SIDE)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [fwt2_pkg::GRID_W-1:0]       cfg_wr_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        op,
    input  logic [fwt2_pkg::COORD_W-1:0]      col_lo,
    input  logic [fwt2_pkg::COORD_W-1:0]      row_lo,
    input  logic [fwt2_pkg::COORD_W-1:0]      col_hi,
    input  logic [fwt2_pkg::COORD_W-1:0]      row_hi,
    input  logic signed [fwt2_pkg::IN_W-1:0]  value,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fwt2_pkg::OUT_W-1:0] sum,
    output logic                              status,
    // memory port
    output fwt2_pkg::mem_ctl_t                mem_ctl,
    output logic [2*AW-1:0]                   mem_addr,
    output logic [VALUE_BITS-1:0]             mem_wdata,
    input  logic [VALUE_BITS-1:0]             mem_rdata,
    // shared adder
    output fwt2_pkg::alu_op_t                 alu_op,
    output logic [VALUE_BITS-1:0]             alu_a,
    output logic [VALUE_BITS-1:0]             alu_b,
    input  logic [VALUE_BITS-1:0]             alu_y
);

    localparam int IW  = AW + 2;
    localparam int MAW = 2 * AW;
    localparam int VB  = VALUE_BITS;
    localparam int GW  = fwt2_pkg::GRID_W;
    localparam int CW  = fwt2_pkg::COORD_W;
    localparam logic [IW-1:0] SIDE_LIM = IW'(MAX_SIDE);

    typedef enum logic [6:0]
    {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_QRY  = 7'b0000100,
        S_DIFF = 7'b0001000,
        S_URD  = 7'b0010000,
        S_UWR  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [GW-1:0]    grid_reg;
    logic [1:0]       op_reg, op_next;
    logic [IW-1:0]    xa_reg, xa_next, xb_reg, xb_next;
    logic [IW-1:0]    ya_reg, ya_next, yb_reg, yb_next;
    logic [IW-1:0]    i_reg, i_next, j_reg, j_next, y_reg, y_next;
    logic [1:0]       corner_reg, corner_next;
    logic             rd_vld_reg, rd_vld_next, rd_neg_reg, rd_neg_next;
    logic [VB-1:0]    v_reg, v_next, delta_reg, delta_next, total_reg, total_next;
    logic             stat_reg, stat_next;
    logic [MAW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [fwt2_pkg::OUT_W-1:0] out_sum_reg, out_sum_next;
    logic             out_stat_reg, out_stat_next;

    logic [GW-1:0]    n_eff;
    logic             bad_cell, bad_rect;
    logic [VB+fwt2_pkg::IN_W-1:0]  v_ext;
    logic [VB+fwt2_pkg::OUT_W-1:0] sum_ext;
    logic [IW-1:0]    lb_i, lb_j, i_dn, j_dn, i_up, j_up, i_m1, j_m1;
    logic [IW-1:0]    cx_next, cy_next;
    logic [1:0]       corner_inc;
    logic             q_issue, slot_free;

    // effective grid bound and range checks
    always_comb
    begin
        n_eff    = (32'(grid_reg) > MAX_SIDE) ? GW'(MAX_SIDE) : grid_reg;
        bad_cell = ({1'b0, col_lo} >= n_eff) || ({1'b0, row_lo} >= n_eff);
        bad_rect = bad_cell || ({1'b0, col_hi} >= n_eff) || ({1'b0, row_hi} >= n_eff);
        v_ext    = {{VB{value[fwt2_pkg::IN_W-1]}}, value};
        sum_ext  = {{fwt2_pkg::OUT_W{1'b0}}, total_reg};
    end

    // index stepping for the tree walks
    always_comb
    begin
        lb_i       = i_reg & (~i_reg + IW'(1));
        lb_j       = j_reg & (~j_reg + IW'(1));
        i_dn       = i_reg & (i_reg - IW'(1));
        j_dn       = j_reg & (j_reg - IW'(1));
        i_up       = i_reg + lb_i;
        j_up       = j_reg + lb_j;
        i_m1       = i_reg - IW'(1);
        j_m1       = j_reg - IW'(1);
        corner_inc = corner_reg + 2'd1;
        cx_next    = corner_inc[1] ? xb_reg : xa_reg;
        cy_next    = corner_inc[0] ? yb_reg : ya_reg;
        q_issue    = (i_reg != '0) && (y_reg != '0);
        slot_free  = !out_valid_reg || !out_stall;
    end

    // shared adder operand selection
    always_comb
    begin
        alu_op = rd_neg_reg ? fwt2_pkg::ALU_SUB : fwt2_pkg::ALU_ADD;
        alu_a  = total_reg;
        alu_b  = mem_rdata;
        if (state_reg == S_DIFF)
        begin
            alu_op = fwt2_pkg::ALU_SUB;
            alu_a  = v_reg;
            alu_b  = total_reg;
        end
        else if (state_reg == S_UWR)
        begin
            alu_op = fwt2_pkg::ALU_ADD;
            alu_a  = mem_rdata;
            alu_b  = delta_reg;
        end
    end

    // memory port drive
    always_comb
    begin
        mem_ctl.en = 1'b0;
        mem_ctl.we = 1'b0;
        mem_addr   = {i_m1[AW-1:0], j_m1[AW-1:0]};
        mem_wdata  = alu_y;
        unique case (state_reg)
            S_CLR:
            begin
                mem_ctl.en = 1'b1;
                mem_ctl.we = 1'b1;
                mem_addr   = clr_cnt_reg;
                mem_wdata  = '0;
            end
            S_QRY:  mem_ctl.en = q_issue;
            S_URD:  mem_ctl.en = 1'b1;
            S_UWR:
            begin
                mem_ctl.en = 1'b1;
                mem_ctl.we = 1'b1;
            end
            default: mem_ctl.en = 1'b0;
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        xa_next        = xa_reg;
        xb_next        = xb_reg;
        ya_next        = ya_reg;
        yb_next        = yb_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        y_next         = y_reg;
        corner_next    = corner_reg;
        rd_vld_next    = 1'b0;
        rd_neg_next    = rd_neg_reg;
        v_next         = v_reg;
        delta_next     = delta_reg;
        total_next     = total_reg;
        stat_next      = stat_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_sum_next   = out_sum_reg;
        out_stat_next  = out_stat_reg;

        // pending prefix read lands in the running total
        if (rd_vld_reg)
        begin
            total_next = alu_y;
        end

        unique case (state_reg)
            S_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + MAW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    v_next      = v_ext[VB-1:0];
                    total_next  = '0;
                    stat_next   = fwt2_pkg::ST_DONE;
                    corner_next = 2'd0;
                    xb_next     = IW'(col_lo);
                    yb_next     = IW'(row_lo);
                    if (op == fwt2_pkg::OP_SUM)
                    begin
                        xa_next = IW'(col_hi) + IW'(1);
                        ya_next = IW'(row_hi) + IW'(1);
                    end
                    else
                    begin
                        xa_next = IW'(col_lo) + IW'(1);
                        ya_next = IW'(row_lo) + IW'(1);
                    end
                    i_next = xa_next;
                    j_next = ya_next;
                    y_next = ya_next;
                    unique case (op)
                        fwt2_pkg::OP_ADD:
                        begin
                            delta_next = v_ext[VB-1:0];
                            stat_next  = bad_cell;
                            state_next = bad_cell ? S_DONE : S_URD;
                        end
                        fwt2_pkg::OP_SET:
                        begin
                            stat_next  = bad_cell;
                            state_next = bad_cell ? S_DONE : S_QRY;
                        end
                        fwt2_pkg::OP_SUM:
                        begin
                            stat_next  = bad_rect;
                            state_next = bad_rect ? S_DONE : S_QRY;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_QRY:
            begin
                if (q_issue)
                begin
                    // one node read per cycle, signed by the corner
                    rd_vld_next = 1'b1;
                    rd_neg_next = corner_reg[1] ^ corner_reg[0];
                    if (j_dn == '0)
                    begin
                        i_next = i_dn;
                        j_next = y_reg;
                    end
                    else
                    begin
                        j_next = j_dn;
                    end
                end
                else if (corner_reg == 2'd3)
                begin
                    state_next = (op_reg == fwt2_pkg::OP_SET) ? S_DIFF : S_DONE;
                end
                else
                begin
                    corner_next = corner_inc;
                    i_next      = cx_next;
                    j_next      = cy_next;
                    y_next      = cy_next;
                end
            end
            S_DIFF:
            begin
                // delta is new value minus old, old stays in the total
                delta_next = alu_y;
                i_next     = xa_reg;
                j_next     = ya_reg;
                y_next     = ya_reg;
                state_next = S_URD;
            end
            S_URD:
            begin
                state_next = S_UWR;
            end
            S_UWR:
            begin
                state_next = S_URD;
                if (j_up > SIDE_LIM)
                begin
                    j_next = y_reg;
                    i_next = i_up;
                    if (i_up > SIDE_LIM)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    j_next = j_up;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = sum_ext[fwt2_pkg::OUT_W-1:0];
                    out_stat_next  = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            grid_reg      <= fwt2_pkg::GRID_RESET;
            clr_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                grid_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        xa_reg       <= xa_next;
        xb_reg       <= xb_next;
        ya_reg       <= ya_next;
        yb_reg       <= yb_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        y_reg        <= y_next;
        corner_reg   <= corner_next;
        rd_neg_reg   <= rd_neg_next;
        v_reg        <= v_next;
        delta_reg    <= delta_next;
        total_reg    <= total_next;
        stat_reg     <= stat_next;
        out_sum_reg  <= out_sum_next;
        out_stat_reg <= out_stat_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign sum       = out_sum_reg;
    assign status    = out_stat_reg;

endmodule
